// ===== rtl/core/nearest_vertex_inside_test_unit_macros.svh =====
// Assertion macros shared by the nearest vertex inside test unit.
`ifndef NEAREST_VERTEX_INSIDE_TEST_UNIT_MACROS_SVH
`define NEAREST_VERTEX_INSIDE_TEST_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define NVIT_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// Next-cycle implication, checked while out of reset.
`define NVIT_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");

`endif

// ===== rtl/core/nvit_pkg.sv =====
// Package with the types and constants of the nearest vertex inside test unit.
`default_nettype none

package nvit_pkg;

   localparam int TYPE_W  = 2;
   localparam int COORD_W = 24;
   localparam int NORM_W  = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int NIDX_W  = 12;
   localparam int WORD_W  = 3 * COORD_W + 3 * NORM_W;

   localparam logic [TYPE_W-1:0] REQ_LOAD  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DOT,
      ST_DOT_WAIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic write_vertex;
      logic clear_count;
      logic cap_query;
      logic scan_start;
      logic scan_issue;
      logic dot_issue;
      logic set_result;
      logic res_accepted;
      logic res_empty;
      logic res_query;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic last_issue;
      logic pipe_idle;
      logic dot_ready;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/nvit_ctrl.sv =====
// Controller state machine sequencing loads, clears, scans and responses.
`default_nettype none

module nvit_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [nvit_pkg::TYPE_W-1:0] req_type,
   output logic                             req_stall,
   input  wire nvit_pkg::sts_type           sts,
   output nvit_pkg::cmd_type                cmd
);
   import nvit_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in       = ST_RESP;
               cmd.set_result = 1'b1;
               case (req_type)
                  REQ_LOAD: begin
                     if (!sts.full) begin
                        cmd.write_vertex = 1'b1;
                        cmd.res_accepted = 1'b1;
                     end
                  end
                  REQ_QUERY: begin
                     if (sts.empty) begin
                        cmd.res_empty = 1'b1;
                     end else begin
                        cmd.set_result = 1'b0;
                        cmd.cap_query  = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_in       = ST_SCAN;
                     end
                  end
                  REQ_CLEAR: begin
                     cmd.clear_count  = 1'b1;
                     cmd.res_accepted = 1'b1;
                  end
                  default: begin
                     // Unused request type: a response of all zeros.
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (sts.pipe_idle) begin
               state_in = ST_DOT;
            end
         end
         ST_DOT: begin
            cmd.dot_issue = 1'b1;
            state_in      = ST_DOT_WAIT;
         end
         ST_DOT_WAIT: begin
            if (sts.dot_ready) begin
               cmd.set_result   = 1'b1;
               cmd.res_accepted = 1'b1;
               cmd.res_query    = 1'b1;
               state_in         = ST_RESP;
            end
         end
         ST_RESP: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/nvit_datapath.sv =====
// Datapath: vertex memory, distance and dot product pipeline, best tracker, output register.
`default_nettype none

`include "nearest_vertex_inside_test_unit_macros.svh"

module nvit_datapath #(
   parameter int MAX_VERTICES = 4096
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic signed [nvit_pkg::COORD_W-1:0] req_coord_x,
   input  wire logic signed [nvit_pkg::COORD_W-1:0] req_coord_y,
   input  wire logic signed [nvit_pkg::COORD_W-1:0] req_coord_z,
   input  wire logic signed [nvit_pkg::NORM_W-1:0]  req_normal_x,
   input  wire logic signed [nvit_pkg::NORM_W-1:0]  req_normal_y,
   input  wire logic signed [nvit_pkg::NORM_W-1:0]  req_normal_z,
   input  wire nvit_pkg::cmd_type                   cmd,
   output nvit_pkg::sts_type                        sts,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_accepted,
   output logic                                     rsp_inside_res,
   output logic [nvit_pkg::NIDX_W-1:0]              rsp_nearest_index,
   output logic                                     rsp_table_empty
);
   import nvit_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int NX = NORM_W;
   localparam int CX = COORD_W;

   // Vertex and normal store, one packed word per entry.
   logic [WORD_W-1:0] mem [MAX_VERTICES];

   logic [CW-1:0] cnt_ff;
   logic [AW-1:0] scan_ff;
   logic          first_ff;

   logic signed [COORD_W-1:0] qx_ff, qy_ff, qz_ff;

   // Stage A: registered memory read.
   logic              va_ff, ma_ff;
   logic [AW-1:0]     ia_ff;
   logic [WORD_W-1:0] rd_ff;
   logic              issue;
   logic [AW-1:0]     rd_addr;

   // Stage B: offsets from vertex to query, normal alongside.
   logic                     vb_ff, mb_ff;
   logic [AW-1:0]            ib_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic signed [NORM_W-1:0] nx_ff, ny_ff, nz_ff;

   // Stage C: products.
   logic                     vc_ff, mc_ff;
   logic [AW-1:0]            ic_ff;
   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [DIFF_W-1:0] ox, oy, oz;

   // Stage D: sum.
   logic                    vd_ff, md_ff;
   logic [AW-1:0]           id_ff;
   logic signed [SUM_W-1:0] s_ff;

   logic signed [SUM_W-1:0] best_d_ff;
   logic [AW-1:0]           best_ff;

   logic                    res_acc_ff, res_in_ff, res_emp_ff;
   logic [AW-1:0]           res_idx_ff;
   logic [NIDX_W+AW-1:0]    idx_wide;

   logic                    rsp_valid_ff;

   assign issue   = cmd.scan_issue | cmd.dot_issue;
   assign rd_addr = cmd.dot_issue ? best_ff : scan_ff;

   always_ff @(posedge clock) begin
      if (cmd.write_vertex) begin
         mem[cnt_ff[AW-1:0]] <= {req_coord_x, req_coord_y, req_coord_z,
                                 req_normal_x, req_normal_y, req_normal_z};
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.clear_count) begin
         cnt_ff <= '0;
      end else if (cmd.write_vertex) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_query) begin
         qx_ff <= req_coord_x;
         qy_ff <= req_coord_y;
         qz_ff <= req_coord_z;
      end
      if (cmd.scan_start) begin
         scan_ff <= '0;
      end else if (cmd.scan_issue) begin
         scan_ff <= scan_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         va_ff <= issue;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff <= cmd.dot_issue;
      ia_ff <= rd_addr;
      mb_ff <= ma_ff;
      ib_ff <= ia_ff;
      dx_ff <= DIFF_W'(qx_ff) - DIFF_W'($signed(rd_ff[WORD_W-1 -: CX]));
      dy_ff <= DIFF_W'(qy_ff) - DIFF_W'($signed(rd_ff[WORD_W-CX-1 -: CX]));
      dz_ff <= DIFF_W'(qz_ff) - DIFF_W'($signed(rd_ff[WORD_W-2*CX-1 -: CX]));
      nx_ff <= $signed(rd_ff[3*NX-1 -: NX]);
      ny_ff <= $signed(rd_ff[2*NX-1 -: NX]);
      nz_ff <= $signed(rd_ff[NX-1 -: NX]);
      mc_ff <= mb_ff;
      ic_ff <= ib_ff;
      px_ff <= dx_ff * ox;
      py_ff <= dy_ff * oy;
      pz_ff <= dz_ff * oz;
      md_ff <= mc_ff;
      id_ff <= ic_ff;
      s_ff  <= SUM_W'(px_ff) + SUM_W'(py_ff) + SUM_W'(pz_ff);
   end

   // One multiplier per axis serves both the squared distance and the dot product.
   assign ox = mb_ff ? DIFF_W'(nx_ff) : dx_ff;
   assign oy = mb_ff ? DIFF_W'(ny_ff) : dy_ff;
   assign oz = mb_ff ? DIFF_W'(nz_ff) : dz_ff;

   // Strict less-than keeps the lowest index on a tie.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         first_ff <= 1'b1;
      end else if (vd_ff && !md_ff) begin
         first_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (vd_ff && !md_ff && (first_ff || (s_ff < best_d_ff))) begin
         best_d_ff <= s_ff;
         best_ff   <= id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_result) begin
         res_acc_ff <= cmd.res_accepted;
         res_emp_ff <= cmd.res_empty;
         res_in_ff  <= cmd.res_query & s_ff[SUM_W-1];
         res_idx_ff <= cmd.res_query ? best_ff : '0;
      end
   end

   assign idx_wide = {{NIDX_W{1'b0}}, res_idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_accepted      <= res_acc_ff;
         rsp_inside_res    <= res_in_ff;
         rsp_nearest_index <= idx_wide[NIDX_W-1:0];
         rsp_table_empty   <= res_emp_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign sts.full       = (cnt_ff == CW'(MAX_VERTICES));
   assign sts.empty      = (cnt_ff == '0);
   assign sts.last_issue = (CW'(scan_ff) == (cnt_ff - CW'(1)));
   assign sts.pipe_idle  = !(va_ff | vb_ff | vc_ff | vd_ff);
   assign sts.dot_ready  = vd_ff & md_ff;
   assign sts.out_free   = !rsp_valid_ff | !rsp_stall;

   `NVIT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, cnt_ff <= CW'(MAX_VERTICES))
   `NVIT_ASSERT_IMP(a_no_write_full, clock, reset, cmd.write_vertex, !sts.full)
   `NVIT_ASSERT_NXT(a_load_shows, clock, reset, cmd.rsp_load, rsp_valid_ff)
   `NVIT_ASSERT_IMP(a_one_dot, clock, reset, 1'b1,
      $countones({va_ff & ma_ff, vb_ff & mb_ff, vc_ff & mc_ff, vd_ff & md_ff}) <= 1)

endmodule

`default_nettype wire

// ===== rtl/core/nearest_vertex_inside_test_unit.sv =====
// Top level of the nearest vertex inside test unit: controller plus datapath.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_type, req_coord_*, req_normal_*
//   rsp_      out        rsp_valid / rsp_stall  accepted, inside_res, nearest_index,
//                                               table_empty
//
// A load, a clear, an unused request type or a query on an empty table goes from ST_IDLE
// to ST_RESP, and its response is loaded into the output register once that is free.
// A query on N stored vertices passes ST_SCAN, ST_DRAIN, ST_DOT and ST_DOT_WAIT: the scan
// reads one vertex a cycle from the vertex memory, the four-stage pipeline drains, and the
// nearest vertex is read once more for the dot product before the controller moves to ST_RESP.
// Reset is synchronous and active high; it empties the table but leaves the memory as it is.
// A stalled response holds in the output register while the next transaction is taken in.
`default_nettype none

module nearest_vertex_inside_test_unit #(
   parameter int MAX_VERTICES = 4096
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [nvit_pkg::TYPE_W-1:0]         req_type,
   input  wire logic signed [nvit_pkg::COORD_W-1:0] req_coord_x,
   input  wire logic signed [nvit_pkg::COORD_W-1:0] req_coord_y,
   input  wire logic signed [nvit_pkg::COORD_W-1:0] req_coord_z,
   input  wire logic signed [nvit_pkg::NORM_W-1:0]  req_normal_x,
   input  wire logic signed [nvit_pkg::NORM_W-1:0]  req_normal_y,
   input  wire logic signed [nvit_pkg::NORM_W-1:0]  req_normal_z,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_accepted,
   output logic                                     rsp_inside_res,
   output logic [nvit_pkg::NIDX_W-1:0]              rsp_nearest_index,
   output logic                                     rsp_table_empty
);
   import nvit_pkg::*;

   // The controller sees only the request valid and type and the status flags, and drives only
   // the commands and req_stall; every register that holds vertex data, distances or results sits in the datapath.
   cmd_type cmd;
   sts_type sts;

   nvit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the vertex memory, the shared multipliers that form the
   // squared distance during the scan and the dot product afterwards, the
   // running best distance (strict compare, so the first of equals wins) and the
   // output register that parts the response side from the request side.
   nvit_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_coord_z       (req_coord_z),
      .req_normal_x      (req_normal_x),
      .req_normal_y      (req_normal_y),
      .req_normal_z      (req_normal_z),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_inside_res    (rsp_inside_res),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_table_empty   (rsp_table_empty)
   );

endmodule

`default_nettype wire
